### hw/rtl/size_class_free_list_allocator_core_macros.svh
// assertion helpers for the pool allocator checker
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define SFLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, quiet while reset is low
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

### hw/rtl/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

    // widest pool number the command carries (up to eight pools)
    localparam int POOL_W = 3;

    // smallest size class in bytes, pool p holds blocks of this << p
    localparam int MIN_CLASS_BYTES = 32;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OOM       = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NULL      = 2'd3;

    // input word
    typedef struct packed {
        logic        func;
        logic [15:0] size_bytes;
        logic        handle_valid;
        logic [7:0]  block_index;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] pool_number;
        logic [7:0] granted_index;
        logic [8:0] free_count;
    } t_out_word;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_REJECT
    } t_cmd_kind;

    // classified command handed from front to back
    typedef struct packed {
        t_cmd_kind         kind;
        logic [POOL_W-1:0] pool;
        logic [7:0]        blk;
        logic [1:0]        rej_status;
    } t_cmd;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } t_bk_state;

endpackage

### hw/rtl/size_class_free_list_allocator_core.sv
`timescale 1ns / 1ps

// Pool allocator with POOL_COUNT pools of CAPACITY fixed-size blocks; pool p
// serves sizes up to 32 << p bytes. An allocate pops the head of the smallest
// pool that fits, a free pushes the block back and raises the pool's free
// count, saturating at CAPACITY. Every request gives one result word. A free
// or a refused request (null handle, size too large, pool empty) is finished
// in the back end's idle state; a granted allocate also passes through the
// read state, since the head's link comes out of the registered read port of
// the link store before the head can move. A two-entry command queue sits
// between the classifying front end and the back end, and the result sits in
// an output register, so requests keep being taken while a result waits.
// After reset the link store is set up by a sweep over all POOL_COUNT *
// CAPACITY entries (1024 with the defaults), during which input is stalled.
module size_class_free_list_allocator_core import sfla_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int POOL_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    logic clearing;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // classify requests
    sfla_front #(
        .CAPACITY   (CAPACITY),
        .POOL_COUNT (POOL_COUNT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // decoupling queue
    sfla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // list operations and result register
    sfla_back #(
        .CAPACITY   (CAPACITY),
        .POOL_COUNT (POOL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### hw/rtl/sfla_front.sv
`timescale 1ns / 1ps

module sfla_front import sfla_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int POOL_COUNT = 4
) (
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    output logic     o_in_stall,
    input  logic     i_q_full,
    input  logic     i_clearing,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic              pool_hit;
    logic [POOL_W-1:0] pool_num;
    logic              blk_ok;

    // smallest size class that fits, searched from the top so the lowest wins
    always_comb begin
        pool_hit = 1'b0;
        pool_num = '0;
        for (int p = POOL_COUNT - 1; p >= 0; p--) begin
            if (int'(i_in_word.size_bytes) <= (MIN_CLASS_BYTES << p)) begin
                pool_hit = 1'b1;
                pool_num = POOL_W'(p);
            end
        end
    end

    assign blk_ok = i_in_word.handle_valid && (int'(i_in_word.block_index) < CAPACITY);

    // classify the request
    always_comb begin
        o_cmd.kind       = CMD_REJECT;
        o_cmd.pool       = pool_num;
        o_cmd.blk        = i_in_word.block_index;
        o_cmd.rej_status = ST_OK;
        if (i_in_word.func == FUNC_FREE && !blk_ok) begin
            o_cmd.rej_status = ST_NULL;
        end else if (!pool_hit) begin
            o_cmd.rej_status = ST_TOO_LARGE;
        end else if (i_in_word.func == FUNC_FREE) begin
            o_cmd.kind = CMD_FREE;
        end else begin
            o_cmd.kind = CMD_ALLOC;
        end
    end

    // hold off while the queue is full or the link store is being set up
    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

### hw/rtl/sfla_queue.sv
`timescale 1ns / 1ps

module sfla_queue import sfla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    // two-entry command queue
    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hw/rtl/sfla_back.sv
`timescale 1ns / 1ps

module sfla_back import sfla_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int POOL_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int DEPTH = POOL_COUNT * CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // link store address of block idx in pool p
    function automatic logic [AW-1:0] link_addr(input logic [PW-1:0] p,
                                                input logic [IDX_W-1:0] idx);
        link_addr = AW'(p) * AW'(CAPACITY) + AW'(idx);
    endfunction

    t_bk_state        r_state;
    t_bk_state        n_state;

    // per-pool list heads and free counters
    logic [IDX_W-1:0] r_head [POOL_COUNT];
    logic [IDX_W-1:0] n_head [POOL_COUNT];
    logic [CNT_W-1:0] r_cnt  [POOL_COUNT];
    logic [CNT_W-1:0] n_cnt  [POOL_COUNT];

    // allocate in flight
    logic [PW-1:0]    r_op_pool;
    logic [PW-1:0]    n_op_pool;
    logic [IDX_W-1:0] r_op_head;
    logic [IDX_W-1:0] n_op_head;

    // clearing sweep position
    logic [PW-1:0]    r_clr_pool;
    logic [PW-1:0]    n_clr_pool;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] n_clr_idx;
    logic             clr_last;

    // output register
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    // link store
    logic [IDX_W-1:0] r_link [DEPTH];
    logic [IDX_W-1:0] r_rd_data;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [IDX_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;

    logic             out_free;
    logic             take;
    logic [PW-1:0]    pool_sel;
    logic [IDX_W-1:0] head_sel;
    logic [CNT_W-1:0] cnt_sel;
    logic [IDX_W-1:0] blk_idx;

    assign pool_sel = i_q_cmd.pool[PW-1:0];
    assign head_sel = r_head[pool_sel];
    assign cnt_sel  = r_cnt[pool_sel];
    assign blk_idx  = IDX_W'(i_q_cmd.blk);
    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = (r_state == BK_IDLE) && !i_q_empty && out_free;
    assign clr_last = (r_clr_pool == PW'(POOL_COUNT - 1)) && (r_clr_idx == IDX_W'(CAPACITY - 1));

    assign o_q_pop     = take;
    assign o_clearing  = (r_state == BK_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (clr_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (take && i_q_cmd.kind == CMD_ALLOC && cnt_sel != '0) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_op_pool   = r_op_pool;
        n_op_head   = r_op_head;
        n_clr_pool  = r_clr_pool;
        n_clr_idx   = r_clr_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wa      = link_addr(r_clr_pool, r_clr_idx);
        mem_wd      = (r_clr_idx == '0) ? '0 : r_clr_idx - IDX_W'(1);
        mem_ra      = link_addr(pool_sel, head_sel);
        unique case (r_state)
            BK_CLEAR: begin
                // each entry links to the one below it, entry 0 to itself
                mem_we = 1'b1;
                if (r_clr_idx == IDX_W'(CAPACITY - 1)) begin
                    n_clr_idx  = '0;
                    n_clr_pool = r_clr_pool + PW'(1);
                end else begin
                    n_clr_idx = r_clr_idx + IDX_W'(1);
                end
            end
            BK_IDLE: begin
                if (take) begin
                    n_out.status        = ST_OK;
                    n_out.pool_number   = 2'(i_q_cmd.pool);
                    n_out.granted_index = '0;
                    n_out.free_count    = '0;
                    unique case (i_q_cmd.kind)
                        CMD_REJECT: begin
                            n_out.status      = i_q_cmd.rej_status;
                            n_out.pool_number = '0;
                            n_out_valid       = 1'b1;
                        end
                        CMD_FREE: begin
                            // push the block on its pool's list
                            mem_we           = 1'b1;
                            mem_wa           = link_addr(pool_sel, blk_idx);
                            mem_wd           = head_sel;
                            n_head[pool_sel] = blk_idx;
                            if (cnt_sel < CNT_W'(CAPACITY)) begin
                                n_cnt[pool_sel] = cnt_sel + CNT_W'(1);
                                n_out.free_count = 9'(cnt_sel + CNT_W'(1));
                            end else begin
                                n_out.free_count = 9'(cnt_sel);
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_ALLOC: begin
                            if (cnt_sel == '0) begin
                                n_out.status = ST_OOM;
                                n_out_valid  = 1'b1;
                            end else begin
                                // link of the head is read this cycle
                                n_op_pool = pool_sel;
                                n_op_head = head_sel;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    endcase
                end
            end
            BK_READ: begin
                // pop: head moves to its link
                n_head[r_op_pool]   = r_rd_data;
                n_cnt[r_op_pool]    = r_cnt[r_op_pool] - CNT_W'(1);
                n_out.status        = ST_OK;
                n_out.pool_number   = 2'(r_op_pool);
                n_out.granted_index = 8'(r_op_head);
                n_out.free_count    = 9'(r_cnt[r_op_pool] - CNT_W'(1));
                n_out_valid         = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_pool  <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_head[p] <= IDX_W'(CAPACITY - 1);
                r_cnt[p]  <= CNT_W'(CAPACITY);
            end
        end else begin
            r_state     <= n_state;
            r_clr_pool  <= n_clr_pool;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op_pool <= n_op_pool;
        r_op_head <= n_op_head;
        r_out     <= n_out;
    end

    // link store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_link[mem_ra];
    end

endmodule

### hw/rtl/sfla_checker.sv
`timescale 1ns / 1ps
`include "size_class_free_list_allocator_core_macros.svh"

module sfla_checker import sfla_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_word i_out_word
);

    logic refused;

    assign refused = (i_out_word.status == ST_TOO_LARGE) || (i_out_word.status == ST_NULL);

    // a stalled result word stays offered
    `SFLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)

    // refused requests carry no pool, block or count
    `SFLA_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n, i_out_valid && refused, i_out_word.pool_number == 2'd0 && i_out_word.granted_index == 8'd0 && i_out_word.free_count == 9'd0)

    // an empty pool reports no block and no free count
    `SFLA_ASSERT_NOW(a_oom_zero, i_clk, i_rst_n, i_out_valid && i_out_word.status == ST_OOM, i_out_word.granted_index == 8'd0 && i_out_word.free_count == 9'd0)

    // free count never passes the pool capacity
    `SFLA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, i_out_valid, int'(i_out_word.free_count) <= CAPACITY)

endmodule

bind size_class_free_list_allocator_core sfla_checker #(
    .CAPACITY (CAPACITY)
) u_sfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);
